// ===== design/sobel_edge_magnitude_assert.svh =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// ===== design/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Widths, register map, controller states and command/status types.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PIX_W        = 8;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int GRAD_W       = 11;
  localparam int SQ_W         = 2 * GRAD_W;
  localparam int ROOT_W       = 16;
  localparam int ROOT_STEPS   = 8;
  localparam int ROOT_CNT_W   = 3;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int REG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_GRAD   = 6'b000100,
    ST_SQUARE = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_DONE   = 6'b100000
  } sem_state_t;

  typedef struct packed {
    logic load_in;
    logic window_shift;
    logic grad_en;
    logic square_en;
    logic root_step;
    logic out_load;
  } sem_cmd_t;

  typedef struct packed {
    logic center_valid;
    logic root_last;
    logic out_free;
  } sem_status_t;

  // Last column index for a width register, with the width held to 3..MAX_WIDTH.
  function automatic logic [COL_W-1:0] last_col_index(input logic [WIDTH_REG_W-1:0] w);
    if (w < WIDTH_REG_W'(3)) begin
      return COL_W'(2);
    end else if (w > WIDTH_REG_W'(MAX_WIDTH)) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return COL_W'(w - WIDTH_REG_W'(1));
    end
  endfunction

  // Last row index for a height register, with the height held to 3..MAX_HEIGHT.
  function automatic logic [ROW_W-1:0] last_row_index(input logic [HEIGHT_REG_W-1:0] h);
    if (h < HEIGHT_REG_W'(3)) begin
      return ROW_W'(2);
    end else if (h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end else begin
      return ROW_W'(h - HEIGHT_REG_W'(1));
    end
  endfunction

endpackage

// ===== design/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel gradient magnitude over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter one word at a time in raster order and each is turned into
// gray as (r + 2g + b) / 4. Every input word yields exactly one output word,
// tagged with the coordinates of the 3x3 window centre, which trails the
// input by one column and one row. Centres in the first two input columns or
// rows are border positions: edge_valid is low and edge_value is zero.
// Interior centres give floor(sqrt(gx^2 + gy^2)) saturated at 255.
// A word whose centre is interior passes through the registered line-store
// read, the gradient sums, the squaring, the eight-step square-root
// iteration and the output load; a border word goes from the read straight
// to the output load. The next word is accepted in the cycle after that
// load, and the load waits while the output register is full. The output
// register lets the next word be accepted while a finished result still
// waits for out_ready; a second result then holds in the controller until
// the first one is taken. The line store needs no clearing pass after
// reset, so words are accepted at once. The image geometry registers lie
// at byte address 0 (image_width) and 4 (image_height) and should be
// written only while the block is idle; values outside 3..1024 and
// 3..4096 are treated as the nearest limit.
module sobel_edge_magnitude
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  red,
  input  logic [PIX_W-1:0]  green,
  input  logic [PIX_W-1:0]  blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  edge_value,
  output logic              edge_valid,
  output logic [COL_W-1:0]  center_col,
  output logic [ROW_W-1:0]  center_row,
  output logic              frame_end
);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [REG_IDX_W-1:0]    reg_idx;
  sem_cmd_t                cmd;
  sem_status_t             status;

  // The port never stalls, so every access cycle completes.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = {{(DATA_W-WIDTH_REG_W){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(DATA_W-HEIGHT_REG_W){1'b0}}, image_height};
      default:          prdata = '0;
    endcase
  end

  // The controller steps each word through the datapath.
  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the line store, window, arithmetic and output word.
  sem_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .image_width  (image_width),
    .image_height (image_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .edge_value   (edge_value),
    .edge_valid   (edge_valid),
    .center_col   (center_col),
    .center_row   (center_row),
    .frame_end    (frame_end)
  );

endmodule

// ===== design/sem_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences one pixel word through read, gradient, square and root steps.
// ----------------------------------------------------------------------------
module sem_ctrl
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sem_status_t status,
  output sem_cmd_t    cmd
);

  sem_state_t state;
  sem_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        // Border centres need no gradient and go straight to the output.
        cmd.window_shift = 1'b1;
        state_next = status.center_valid ? ST_GRAD : ST_DONE;
      end
      ST_GRAD: begin
        cmd.grad_en = 1'b1;
        state_next  = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square_en = 1'b1;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sem_dp.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Gray conversion, line store, window, gradients, square root, output word.
// ----------------------------------------------------------------------------
module sem_dp
  import sem_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  sem_cmd_t                cmd,
  output sem_status_t             status,
  input  logic [PIX_W-1:0]        red,
  input  logic [PIX_W-1:0]        green,
  input  logic [PIX_W-1:0]        blue,
  input  logic [WIDTH_REG_W-1:0]  image_width,
  input  logic [HEIGHT_REG_W-1:0] image_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIX_W-1:0]        edge_value,
  output logic                    edge_valid,
  output logic [COL_W-1:0]        center_col,
  output logic [ROW_W-1:0]        center_row,
  output logic                    frame_end
);

  // Each word holds {row two above, row one above} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_word;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] gray_q;
  logic             valid_q;
  logic             frame_end_q;
  logic [COL_W-1:0] center_col_q;
  logic [ROW_W-1:0] center_row_q;

  logic [PIX_W-1:0] win [9];

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic [ROOT_W-1:0]        rem;
  logic [ROOT_W-1:0]        res;
  logic [ROOT_W-1:0]        root_bit;
  logic [ROOT_CNT_W-1:0]    root_cnt;
  logic                     sat;

  logic [PIX_W+1:0]         gray_sum;
  logic                     last_col;
  logic                     last_row;
  logic signed [GRAD_W-1:0] px [9];
  logic signed [GRAD_W-1:0] gx_comb;
  logic signed [GRAD_W-1:0] gy_comb;
  logic signed [SQ_W-1:0]   sq_sum;
  logic [ROOT_W:0]          trial;

  assign gray_sum = {2'b00, red} + {1'b0, green, 1'b0} + {2'b00, blue};
  assign last_col = col_count >= last_col_index(image_width);
  assign last_row = row_count >= last_row_index(image_height);

  // Position counters and per-word tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.load_in) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_q        <= col_count;
      gray_q       <= gray_sum[PIX_W+1:2];
      valid_q      <= (col_count >= COL_W'(2)) && (row_count >= ROW_W'(2));
      frame_end_q  <= last_col && last_row;
      center_col_q <= (col_count == '0) ? '0 : col_count - COL_W'(1);
      center_row_q <= (row_count == '0) ? '0 : row_count - ROW_W'(1);
    end
  end

  // Line store: read on acceptance, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rd_word <= line_mem[col_count];
    end
    if (cmd.window_shift) begin
      line_mem[col_q] <= {rd_word[PIX_W-1:0], gray_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.window_shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= rd_word[2*PIX_W-1:PIX_W];
      win[5] <= rd_word[PIX_W-1:0];
      win[8] <= gray_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      px[i] = $signed({{(GRAD_W-PIX_W){1'b0}}, win[i]});
    end
    gx_comb = (px[2] + (px[5] <<< 1) + px[8]) - (px[0] + (px[3] <<< 1) + px[6]);
    gy_comb = (px[6] + (px[7] <<< 1) + px[8]) - (px[0] + (px[1] <<< 1) + px[2]);
  end

  assign sq_sum = (SQ_W'(gx) * SQ_W'(gx)) + (SQ_W'(gy) * SQ_W'(gy));
  assign trial  = {1'b0, res} + {1'b0, root_bit};

  always_ff @(posedge clk) begin
    if (cmd.grad_en) begin
      gx <= gx_comb;
      gy <= gy_comb;
    end
  end

  // Bit-pair restoring square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.square_en) begin
      sat      <= |sq_sum[SQ_W-1:ROOT_W];
      rem      <= sq_sum[ROOT_W-1:0];
      res      <= '0;
      root_bit <= ROOT_W'(1) << (ROOT_W - 2);
      root_cnt <= '0;
    end else if (cmd.root_step) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[ROOT_W-1:0];
        res <= (res >> 1) + root_bit;
      end else begin
        res <= res >> 1;
      end
      root_bit <= root_bit >> 2;
      root_cnt <= root_cnt + ROOT_CNT_W'(1);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      edge_value <= !valid_q ? '0 : (sat ? {PIX_W{1'b1}} : res[PIX_W-1:0]);
      edge_valid <= valid_q;
      center_col <= center_col_q;
      center_row <= center_row_q;
      frame_end  <= frame_end_q;
    end
  end

  assign status.center_valid = valid_q;
  assign status.root_last    = root_cnt == ROOT_CNT_W'(ROOT_STEPS - 1);
  assign status.out_free     = !out_valid || out_ready;

endmodule

// ===== design/sem_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude port checker
// Watches the stream ports of the top level for ordering and output rules.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_assert.svh"

module sem_checker
  import sem_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] edge_value,
  input logic             edge_valid,
  input logic             frame_end
);

  // A result word that is not taken stays on offer.
  `SEM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // Only one pixel word is in flight, so ready drops after an acceptance.
  `SEM_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // A border centre carries a zero magnitude.
  `SEM_ASSERT_SAME(a_border_zero, clk, rst, out_valid && !edge_valid, edge_value == '0)

  // The last pixel of a frame always has an interior window centre.
  `SEM_ASSERT_SAME(a_frame_end_valid, clk, rst, out_valid && frame_end, edge_valid)

endmodule

bind sobel_edge_magnitude sem_checker u_checker (.*);
